FILE: src/sarq_pkg.sv
// Shared constants, types and the arctangent table of the shortest-arc quaternion block.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package sarq_pkg;

    localparam int DEF_COMPONENT_BITS = 16;
    localparam int DEF_CORDIC_STAGES  = 16;

    localparam int WORK_BITS = 16;
    localparam int QMAX      = 16384;

    // CORDIC datapath width: Q30 angles and Q28 magnitudes with gain headroom.
    localparam int CW = 33;
    typedef logic signed [CW-1:0] cword_t;

    localparam cword_t ONE_Q28     = 33'sd268435456;
    localparam cword_t KINV_Q28    = 33'sd163008218;
    localparam cword_t HALF_PI_Q30 = 33'sd1686629713;
    localparam cword_t W_ROUND     = 33'sd8192;

    // Square root lanes: 64-bit radicand, one result bit per cell.
    localparam int SQ_W      = 64;
    localparam int SQ_STAGES = SQ_W / 2;

    // Axis scaling divider: one quotient bit per cell.
    localparam int DIV_W   = 64;
    localparam int DIV_Q_W = 17;

    typedef enum logic [1:0] {
        STAT_NORMAL = 2'd0,
        STAT_EQUAL  = 2'd1,
        STAT_DEGEN  = 2'd2
    } status_t;

    // atan(2^-i) in Q30 radians, rounded down.
    function automatic cword_t arc_q30(input int i);
        cword_t r;
        case (i)
            0:  r = 33'sd843314856;
            1:  r = 33'sd497837829;
            2:  r = 33'sd263043836;
            3:  r = 33'sd133525158;
            4:  r = 33'sd67021686;
            5:  r = 33'sd33543515;
            6:  r = 33'sd16775850;
            7:  r = 33'sd8388437;
            8:  r = 33'sd4194282;
            9:  r = 33'sd2097149;
            10: r = 33'sd1048575;
            11: r = 33'sd524287;
            12: r = 33'sd262143;
            13: r = 33'sd131071;
            default: begin
                if (i <= 30) r = (cword_t'(1) <<< (30 - i)) - cword_t'(1);
                else r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/sarq_sqrt_cell.sv
// One cell of the pipelined integer square root: settles one result bit per lane.
// Depends on sarq_pkg.
`default_nettype none

module sarq_sqrt_cell #(
    parameter int STAGE  = 0,
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  logic [LANES-1:0][sarq_pkg::SQ_W-1:0]  in_v,
    input  logic [LANES-1:0][sarq_pkg::SQ_W-1:0]  in_r,
    input  logic [SIDE_W-1:0]                     in_side,
    output logic                                  out_valid,
    output logic [LANES-1:0][sarq_pkg::SQ_W-1:0]  out_v,
    output logic [LANES-1:0][sarq_pkg::SQ_W-1:0]  out_r,
    output logic [SIDE_W-1:0]                     out_side
);
    import sarq_pkg::*;

    localparam int BITPOS = SQ_W - 2 - 2 * STAGE;
    localparam logic [SQ_W-1:0] BIT = {{(SQ_W-1){1'b0}}, 1'b1} << BITPOS;

    logic                        valid_reg;
    logic [LANES-1:0][SQ_W-1:0]  v_reg, v_next;
    logic [LANES-1:0][SQ_W-1:0]  r_reg, r_next;
    logic [SIDE_W-1:0]           side_reg;
    logic [LANES-1:0][SQ_W:0]    trial;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            trial[l] = {1'b0, in_r[l]} + {1'b0, BIT};
            if ({1'b0, in_v[l]} >= trial[l]) begin
                v_next[l] = in_v[l] - trial[l][SQ_W-1:0];
                r_next[l] = (in_r[l] >> 1) + BIT;
            end else begin
                v_next[l] = in_v[l];
                r_next[l] = in_r[l] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            v_reg    <= v_next;
            r_reg    <= r_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_v     = v_reg;
    assign out_r     = r_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

FILE: src/sarq_cordic_cell.sv
// One CORDIC micro-rotation cell, in vectoring or rotation mode, with its own arctangent.
// Depends on sarq_pkg.
`default_nettype none

module sarq_cordic_cell #(
    parameter int STAGE     = 0,
    parameter bit VECTORING = 1'b0,
    parameter int SIDE_W    = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    in_valid,
    input  sarq_pkg::cword_t        in_x,
    input  sarq_pkg::cword_t        in_y,
    input  sarq_pkg::cword_t        in_z,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output sarq_pkg::cword_t        out_x,
    output sarq_pkg::cword_t        out_y,
    output sarq_pkg::cword_t        out_z,
    output logic [SIDE_W-1:0]       out_side
);
    import sarq_pkg::*;

    localparam cword_t ARC = arc_q30(STAGE);

    logic              valid_reg;
    cword_t            x_reg, y_reg, z_reg;
    cword_t            x_next, y_next, z_next;
    cword_t            sx, sy;
    logic              up;
    logic [SIDE_W-1:0] side_reg;

    always_comb begin
        sx = in_y >>> STAGE;
        sy = in_x >>> STAGE;
        // Vectoring drives y toward zero; rotation drives the residual angle toward zero.
        up = VECTORING ? in_y[CW-1] : !in_z[CW-1];
        if (up) begin
            x_next = in_x - sx;
            y_next = in_y + sy;
            z_next = in_z - ARC;
        end else begin
            x_next = in_x + sx;
            y_next = in_y - sy;
            z_next = in_z + ARC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

FILE: src/sarq_div_cell.sv
// One cell of the restoring divider that scales the axis: one quotient bit per lane.
// Depends on sarq_pkg.
`default_nettype none

module sarq_div_cell #(
    parameter int STAGE  = 0,
    parameter int LANES  = 3,
    parameter int SIDE_W = 1
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     adv,
    input  logic                                     in_valid,
    input  logic [LANES-1:0][sarq_pkg::DIV_W-1:0]    in_rem,
    input  logic [LANES-1:0][sarq_pkg::DIV_Q_W-1:0]  in_q,
    input  logic [sarq_pkg::DIV_W-1:0]               in_den,
    input  logic [SIDE_W-1:0]                        in_side,
    output logic                                     out_valid,
    output logic [LANES-1:0][sarq_pkg::DIV_W-1:0]    out_rem,
    output logic [LANES-1:0][sarq_pkg::DIV_Q_W-1:0]  out_q,
    output logic [sarq_pkg::DIV_W-1:0]               out_den,
    output logic [SIDE_W-1:0]                        out_side
);
    import sarq_pkg::*;

    localparam int K = DIV_Q_W - 1 - STAGE;
    localparam logic [DIV_Q_W-1:0] QBIT = {{(DIV_Q_W-1){1'b0}}, 1'b1} << K;

    logic                          valid_reg;
    logic [LANES-1:0][DIV_W-1:0]   rem_reg, rem_next;
    logic [LANES-1:0][DIV_Q_W-1:0] q_reg, q_next;
    logic [DIV_W-1:0]              den_reg;
    logic [DIV_W-1:0]              trial;
    logic [SIDE_W-1:0]             side_reg;

    always_comb begin
        trial = in_den << K;
        for (int l = 0; l < LANES; l++) begin
            if (in_rem[l] >= trial) begin
                rem_next[l] = in_rem[l] - trial;
                q_next[l]   = in_q[l] | QBIT;
            end else begin
                rem_next[l] = in_rem[l];
                q_next[l]   = in_q[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

FILE: src/shortest_arc_quaternion.sv
// Top level of the shortest-arc quaternion block: front end, cell chains and output register.
// Depends on sarq_pkg, sarq_sqrt_cell, sarq_cordic_cell and sarq_div_cell.
`default_nettype none

// Takes one pair of 3-D vectors per clock and returns the unit quaternion (Q1.14) that turns
// the first onto the second, with a status: identity for equal vectors, all zeros for a zero
// cross product. The datapath is one fully pipelined chain: five front-end stages (input,
// products, cross and dot sums, squares, radicands), 32 square-root cells, CORDIC_STAGES vectoring and
// CORDIC_STAGES rotation cells, two scaling stages, 17 divider cells and the output register.
// One request is taken every cycle while the output is not stalled. The whole chain advances
// together and holds while a result waits on m_tready.
module shortest_arc_quaternion #(
    parameter int COMPONENT_BITS = sarq_pkg::DEF_COMPONENT_BITS,
    parameter int CORDIC_STAGES  = sarq_pkg::DEF_CORDIC_STAGES
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // from_x, from_y, from_z, to_x, to_y, to_z, zero padding
    input  logic [((6*COMPONENT_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [63:0]                               m_tdata,
    // status
    output logic [1:0]                                m_tuser
);
    import sarq_pkg::*;

    localparam int CB     = COMPONENT_BITS;
    localparam int C_W    = 33;
    localparam int DC_W   = 30;
    localparam int N_W    = SQ_W / 2;
    localparam int S_W    = 29;
    localparam int SIDE1_W = 3 * C_W + DC_W + 1 + 2;
    localparam int SIDE2_W = 3 * C_W + N_W + 1 + 2;
    localparam int SIDE3_W = 3 * C_W + N_W + 2;
    localparam int SIDE4_W = 3 + WORK_BITS + 2;

    localparam logic signed [33:0] D_HI = 34'sd268435456;
    localparam logic signed [33:0] D_LO = -34'sd268435456;
    localparam logic signed [DC_W-1:0] DC_MIN = -30'sd268435456;

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- input unpacking ----------------
    logic [CB-1:0]               comp [6];
    logic signed [WORK_BITS-1:0] work [6];
    logic                        eq;

    for (genvar k = 0; k < 6; k++) begin : g_unpack
        assign comp[k] = s_tdata[k*CB +: CB];
        if (CB > WORK_BITS) begin : g_down
            assign work[k] = comp[k][CB-1 -: WORK_BITS];
        end else if (CB == WORK_BITS) begin : g_same
            assign work[k] = comp[k];
        end else begin : g_up
            assign work[k] = {comp[k], {(WORK_BITS-CB){1'b0}}};
        end
    end

    assign eq = (comp[0] == comp[3]) && (comp[1] == comp[4]) && (comp[2] == comp[5]);

    // ---------------- front end ----------------
    logic                        va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    logic signed [WORK_BITS-1:0] a_reg [3];
    logic signed [WORK_BITS-1:0] b_reg [3];
    logic                        eqa_reg, eqb_reg;
    logic signed [31:0]          p_reg [3][3];
    logic signed [31:0]          p_next [3][3];

    logic signed [C_W-1:0]       c_next [3];
    logic signed [33:0]          d_sum;
    logic signed [DC_W-1:0]      dc_next;
    status_t                     stc_next;
    logic [2:0][C_W-1:0]         c_reg;
    logic signed [DC_W-1:0]      dc_reg;
    status_t                     stc_reg;

    logic [31:0]                 cm [3];
    logic signed [C_W-1:0]       cneg [3];
    logic [63:0]                 sq_next [3];
    logic [63:0]                 sq_reg [3];
    logic signed [59:0]          dsq_next, dsq_reg;
    logic [2:0][C_W-1:0]         cd_reg;
    logic signed [DC_W-1:0]      dcd_reg;
    status_t                     std_reg;

    logic [SQ_W-1:0]             norm2_reg, sval_reg;
    logic [2:0][C_W-1:0]         ce_reg;
    logic signed [DC_W-1:0]      dce_reg;
    status_t                     ste_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p_next[i][j] = a_reg[i] * b_reg[j];
            end
        end
    end

    always_comb begin
        c_next[0] = $signed({p_reg[1][2][31], p_reg[1][2]}) - $signed({p_reg[2][1][31], p_reg[2][1]});
        c_next[1] = $signed({p_reg[2][0][31], p_reg[2][0]}) - $signed({p_reg[0][2][31], p_reg[0][2]});
        c_next[2] = $signed({p_reg[0][1][31], p_reg[0][1]}) - $signed({p_reg[1][0][31], p_reg[1][0]});
        d_sum = $signed({{2{p_reg[0][0][31]}}, p_reg[0][0]})
              + $signed({{2{p_reg[1][1][31]}}, p_reg[1][1]})
              + $signed({{2{p_reg[2][2][31]}}, p_reg[2][2]});
        if (d_sum > D_HI) dc_next = D_HI[DC_W-1:0];
        else if (d_sum < D_LO) dc_next = D_LO[DC_W-1:0];
        else dc_next = d_sum[DC_W-1:0];
        if (eqb_reg) stc_next = STAT_EQUAL;
        else if (c_next[0] == '0 && c_next[1] == '0 && c_next[2] == '0) stc_next = STAT_DEGEN;
        else stc_next = STAT_NORMAL;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cneg[k]    = -$signed(c_reg[k]);
            cm[k]      = c_reg[k][C_W-1] ? cneg[k][31:0] : c_reg[k][31:0];
            sq_next[k] = cm[k] * cm[k];
        end
        dsq_next = dc_reg * dc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                a_reg[k] <= work[k];
                b_reg[k] <= work[k+3];
            end
            eqa_reg <= eq;

            p_reg   <= p_next;
            eqb_reg <= eqa_reg;

            for (int k = 0; k < 3; k++) c_reg[k] <= c_next[k];
            dc_reg  <= dc_next;
            stc_reg <= stc_next;

            sq_reg  <= sq_next;
            dsq_reg <= dsq_next;
            cd_reg  <= c_reg;
            dcd_reg <= dc_reg;
            std_reg <= stc_reg;

            norm2_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sval_reg  <= (64'd1 << 56) - {7'b0, dsq_reg[56:0]};
            ce_reg    <= cd_reg;
            dce_reg   <= dcd_reg;
            ste_reg   <= std_reg;
        end
    end

    // ---------------- square root chain: |c| and sin(angle) ----------------
    logic                        sq_valid [0:SQ_STAGES];
    logic [1:0][SQ_W-1:0]        sq_v     [0:SQ_STAGES];
    logic [1:0][SQ_W-1:0]        sq_r     [0:SQ_STAGES];
    logic [SIDE1_W-1:0]          sq_side  [0:SQ_STAGES];

    assign sq_valid[0] = ve_reg;
    assign sq_v[0]     = {sval_reg, norm2_reg};
    assign sq_r[0]     = '0;
    assign sq_side[0]  = {ce_reg, dce_reg, (dce_reg == DC_MIN), ste_reg};

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
        sarq_sqrt_cell #(
            .STAGE  (k),
            .LANES  (2),
            .SIDE_W (SIDE1_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (sq_valid[k]),
            .in_v      (sq_v[k]),
            .in_r      (sq_r[k]),
            .in_side   (sq_side[k]),
            .out_valid (sq_valid[k+1]),
            .out_v     (sq_v[k+1]),
            .out_r     (sq_r[k+1]),
            .out_side  (sq_side[k+1])
        );
    end

    logic [2:0][C_W-1:0]    s1_c;
    logic signed [DC_W-1:0] s1_dc;
    logic                   s1_dneg;
    logic [1:0]             s1_st;
    logic [N_W-1:0]         s1_n;
    logic [S_W-1:0]         s1_s;

    assign {s1_c, s1_dc, s1_dneg, s1_st} = sq_side[SQ_STAGES];
    assign s1_n = sq_r[SQ_STAGES][0][N_W-1:0];
    assign s1_s = sq_r[SQ_STAGES][1][S_W-1:0];

    // ---------------- vectoring CORDIC: half the turn angle ----------------
    logic               vc_valid [0:CORDIC_STAGES];
    cword_t             vc_x     [0:CORDIC_STAGES];
    cword_t             vc_y     [0:CORDIC_STAGES];
    cword_t             vc_z     [0:CORDIC_STAGES];
    logic [SIDE2_W-1:0] vc_side  [0:CORDIC_STAGES];

    assign vc_valid[0] = sq_valid[SQ_STAGES];
    assign vc_x[0]     = ONE_Q28 + $signed({{(CW-DC_W){s1_dc[DC_W-1]}}, s1_dc});
    assign vc_y[0]     = $signed({{(CW-S_W){1'b0}}, s1_s});
    assign vc_z[0]     = '0;
    assign vc_side[0]  = {s1_c, s1_n, s1_dneg, s1_st};

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
        sarq_cordic_cell #(
            .STAGE     (k),
            .VECTORING (1'b1),
            .SIDE_W    (SIDE2_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (vc_valid[k]),
            .in_x      (vc_x[k]),
            .in_y      (vc_y[k]),
            .in_z      (vc_z[k]),
            .in_side   (vc_side[k]),
            .out_valid (vc_valid[k+1]),
            .out_x     (vc_x[k+1]),
            .out_y     (vc_y[k+1]),
            .out_z     (vc_z[k+1]),
            .out_side  (vc_side[k+1])
        );
    end

    logic [2:0][C_W-1:0] s2_c;
    logic [N_W-1:0]      s2_n;
    logic                s2_dneg;
    logic [1:0]          s2_st;

    assign {s2_c, s2_n, s2_dneg, s2_st} = vc_side[CORDIC_STAGES];

    // ---------------- rotation CORDIC: cos and sin of the half angle ----------------
    logic               rc_valid [0:CORDIC_STAGES];
    cword_t             rc_x     [0:CORDIC_STAGES];
    cword_t             rc_y     [0:CORDIC_STAGES];
    cword_t             rc_z     [0:CORDIC_STAGES];
    logic [SIDE3_W-1:0] rc_side  [0:CORDIC_STAGES];

    // Opposite vectors turn by pi, so the half angle is pi/2 outright.
    assign rc_valid[0] = vc_valid[CORDIC_STAGES];
    assign rc_x[0]     = KINV_Q28;
    assign rc_y[0]     = '0;
    assign rc_z[0]     = s2_dneg ? HALF_PI_Q30 : vc_z[CORDIC_STAGES];
    assign rc_side[0]  = {s2_c, s2_n, s2_st};

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
        sarq_cordic_cell #(
            .STAGE     (k),
            .VECTORING (1'b0),
            .SIDE_W    (SIDE3_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (rc_valid[k]),
            .in_x      (rc_x[k]),
            .in_y      (rc_y[k]),
            .in_z      (rc_z[k]),
            .in_side   (rc_side[k]),
            .out_valid (rc_valid[k+1]),
            .out_x     (rc_x[k+1]),
            .out_y     (rc_y[k+1]),
            .out_z     (rc_z[k+1]),
            .out_side  (rc_side[k+1])
        );
    end

    logic [2:0][C_W-1:0] s3_c;
    logic [N_W-1:0]      s3_n;
    logic [1:0]          s3_st;

    assign {s3_c, s3_n, s3_st} = rc_side[CORDIC_STAGES];

    // ---------------- axis scaling: products, then dividend ----------------
    logic                        vp_reg, vq_reg;
    cword_t                      wt;
    logic signed [WORK_BITS-1:0] w_next, wp_reg, wq_reg;
    logic signed [2*C_W-1:0]     num_next [3];
    logic signed [2*C_W-1:0]     num_reg  [3];
    logic signed [2*C_W-1:0]     num_neg  [3];
    logic [N_W-1:0]              np_reg;
    logic [1:0]                  stp_reg, stq_reg;
    logic [2:0][DIV_W-1:0]       dvd_reg;
    logic [DIV_W-1:0]            den_reg;
    logic [2:0]                  negq_reg;

    always_comb begin
        wt = (rc_x[CORDIC_STAGES] + W_ROUND) >>> 14;
        if (wt > cword_t'(QMAX)) w_next = WORK_BITS'(QMAX);
        else if (wt < -cword_t'(QMAX)) w_next = -WORK_BITS'(QMAX);
        else w_next = wt[WORK_BITS-1:0];
        for (int k = 0; k < 3; k++) begin
            num_next[k] = $signed(s3_c[k]) * rc_y[CORDIC_STAGES];
            num_neg[k]  = -num_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
            vq_reg <= 1'b0;
        end else if (adv) begin
            vp_reg <= rc_valid[CORDIC_STAGES];
            vq_reg <= vp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_reg <= num_next;
            wp_reg  <= w_next;
            np_reg  <= s3_n;
            stp_reg <= s3_st;

            // Half the divisor is added first so the quotient rounds to nearest.
            for (int k = 0; k < 3; k++) begin
                negq_reg[k] <= num_reg[k][2*C_W-1];
                dvd_reg[k]  <= (num_reg[k][2*C_W-1] ? num_neg[k][DIV_W-1:0]
                                                    : num_reg[k][DIV_W-1:0])
                             + {19'b0, np_reg, 13'b0};
            end
            den_reg <= {18'b0, np_reg, 14'b0};
            wq_reg  <= wp_reg;
            stq_reg <= stp_reg;
        end
    end

    // ---------------- divider chain ----------------
    logic                        dv_valid [0:DIV_Q_W];
    logic [2:0][DIV_W-1:0]       dv_rem   [0:DIV_Q_W];
    logic [2:0][DIV_Q_W-1:0]     dv_q     [0:DIV_Q_W];
    logic [DIV_W-1:0]            dv_den   [0:DIV_Q_W];
    logic [SIDE4_W-1:0]          dv_side  [0:DIV_Q_W];

    assign dv_valid[0] = vq_reg;
    assign dv_rem[0]   = dvd_reg;
    assign dv_q[0]     = '0;
    assign dv_den[0]   = den_reg;
    assign dv_side[0]  = {negq_reg, wq_reg, stq_reg};

    for (genvar k = 0; k < DIV_Q_W; k++) begin : g_div
        sarq_div_cell #(
            .STAGE  (k),
            .LANES  (3),
            .SIDE_W (SIDE4_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (dv_valid[k]),
            .in_rem    (dv_rem[k]),
            .in_q      (dv_q[k]),
            .in_den    (dv_den[k]),
            .in_side   (dv_side[k]),
            .out_valid (dv_valid[k+1]),
            .out_rem   (dv_rem[k+1]),
            .out_q     (dv_q[k+1]),
            .out_den   (dv_den[k+1]),
            .out_side  (dv_side[k+1])
        );
    end

    // ---------------- result assembly and output register ----------------
    logic [2:0]                  f_neg;
    logic [WORK_BITS-1:0]        f_w;
    logic [1:0]                  f_st;
    logic [WORK_BITS-1:0]        f_mag [3];
    logic [WORK_BITS-1:0]        f_ax  [3];
    logic [63:0]                 tdata_next;
    logic                        m_tvalid_reg;
    logic [63:0]                 m_tdata_reg;
    logic [1:0]                  m_tuser_reg;

    assign {f_neg, f_w, f_st} = dv_side[DIV_Q_W];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (dv_q[DIV_Q_W][k] > DIV_Q_W'(QMAX)) f_mag[k] = WORK_BITS'(QMAX);
            else f_mag[k] = dv_q[DIV_Q_W][k][WORK_BITS-1:0];
            f_ax[k] = f_neg[k] ? -f_mag[k] : f_mag[k];
        end
        unique case (status_t'(f_st))
            STAT_EQUAL:  tdata_next = {48'b0, 16'(QMAX)};
            STAT_DEGEN:  tdata_next = '0;
            default:     tdata_next = {f_ax[2], f_ax[1], f_ax[0], f_w};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dv_valid[DIV_Q_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= tdata_next;
            m_tuser_reg <= f_st;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_equal_identity : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_EQUAL) |-> (m_tdata == {48'b0, 16'(QMAX)}))
        else $error("equal-vector result is not the identity");

    a_degen_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_DEGEN) |-> (m_tdata == 64'b0))
        else $error("degenerate result is not all zeros");

    a_normal_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_NORMAL) |->
        ($signed(m_tdata[15:0]) <= 16'sd16384 && $signed(m_tdata[15:0]) >= -16'sd16384 &&
         $signed(m_tdata[31:16]) <= 16'sd16384 && $signed(m_tdata[31:16]) >= -16'sd16384 &&
         $signed(m_tdata[47:32]) <= 16'sd16384 && $signed(m_tdata[47:32]) >= -16'sd16384 &&
         $signed(m_tdata[63:48]) <= 16'sd16384 && $signed(m_tdata[63:48]) >= -16'sd16384))
        else $error("quaternion part outside unit range");

    a_stall_holds_pipe : assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vq_reg) && $stable(ve_reg))
        else $error("pipeline moved while the result was blocked");
`endif

endmodule

`default_nettype wire
